[rtl/core/dmrs_pkg.sv]
// ----------------------------------------------------------------------------
// dmrs_pkg: shared types and constants of the display mode register sequencer
// Holds the clock frequency tables, register offsets, control-word masks and
// the job record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package dmrs_pkg;

  // Frequency table sizes and the number of entries actually searched.
  localparam int PANEL_FREQ_ENTRIES = 48;
  localparam int CRT_FREQ_ENTRIES   = 32;
  localparam int PANEL_TABLE_LEN    = 48;
  localparam int CRT_TABLE_LEN      = 32;
  localparam int PANEL_COUNT = (PANEL_FREQ_ENTRIES < 1) ? 1 :
      ((PANEL_FREQ_ENTRIES > PANEL_TABLE_LEN) ? PANEL_TABLE_LEN : PANEL_FREQ_ENTRIES);
  localparam int CRT_COUNT = (CRT_FREQ_ENTRIES < 1) ? 1 :
      ((CRT_FREQ_ENTRIES > CRT_TABLE_LEN) ? CRT_TABLE_LEN : CRT_FREQ_ENTRIES);

  // Stream payload widths.
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int OFFSET_W   = 21;

  // Register offsets.
  localparam logic [OFFSET_W-1:0] OFF_CLK0       = 21'h0003C;
  localparam logic [OFFSET_W-1:0] OFF_CLK1       = 21'h00044;
  localparam logic [OFFSET_W-1:0] OFF_CLK2       = 21'h0004C;
  localparam logic [OFFSET_W-1:0] OFF_DISP_CTRL  = 21'h80000;
  localparam logic [OFFSET_W-1:0] OFF_P_OFFS     = 21'h80010;
  localparam logic [OFFSET_W-1:0] OFF_P_FB_W     = 21'h80014;
  localparam logic [OFFSET_W-1:0] OFF_P_FB_H     = 21'h80018;
  localparam logic [OFFSET_W-1:0] OFF_P_SIZE     = 21'h80020;
  localparam logic [OFFSET_W-1:0] OFF_P_HTOT     = 21'h80024;
  localparam logic [OFFSET_W-1:0] OFF_P_HSYN     = 21'h80028;
  localparam logic [OFFSET_W-1:0] OFF_P_VTOT     = 21'h8002C;
  localparam logic [OFFSET_W-1:0] OFF_P_VSYN     = 21'h80030;
  localparam logic [OFFSET_W-1:0] OFF_CRT_CTRL   = 21'h80200;
  localparam logic [OFFSET_W-1:0] OFF_C_OFFS     = 21'h80208;
  localparam logic [OFFSET_W-1:0] OFF_C_HTOT     = 21'h8020C;
  localparam logic [OFFSET_W-1:0] OFF_C_HSYN     = 21'h80210;
  localparam logic [OFFSET_W-1:0] OFF_C_VTOT     = 21'h80214;
  localparam logic [OFFSET_W-1:0] OFF_C_VSYN     = 21'h80218;

  // Control-word constants.
  localparam logic [31:0] CRT_CTRL_BASE    = 32'h00010304;
  localparam logic [31:0] CRT_SYNC_PHASE   = 32'h0000C000;
  localparam logic [31:0] PANEL_CLK_FIELD  = 32'h3F000000;
  localparam logic [31:0] CRT_CLK_FIELD    = 32'h001F0000;
  localparam logic [31:0] PANEL_SRC        = 32'h20000000;
  localparam logic [31:0] CRT_SRC          = 32'h00100000;
  localparam logic [31:0] DISP_CLK_POL     = 32'h00004000;
  localparam logic [31:0] DISP_STN_TYPE    = 32'h000C0000;
  localparam logic [31:0] DISP_SIG_EN      = 32'h0F000000;
  localparam logic [31:0] DISP_LOW_BITS    = 32'h00000003;
  localparam logic [31:0] DISP_ENABLE      = 32'h00000004;
  localparam logic [31:0] PRESET0_CLK0     = 32'h0A1A0201;
  localparam logic [31:0] PRESET0_CLK1     = 32'h0A1A0A09;
  localparam logic [31:0] PRESET1_CLK      = 32'h291A0201;

  // Target codes; bit 1 alone selects the CRT.
  localparam logic [1:0] TARGET_PANEL_ON  = 2'd0;
  localparam logic [1:0] TARGET_PANEL_OFF = 2'd1;

  // Sequencer steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] CRT_LAST_STEP   = 4'd8;
  localparam logic [STEP_W-1:0] PANEL_LAST_STEP = 4'd11;

  // Job queue.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [31:0] PANEL_HZ [PANEL_TABLE_LEN] = '{
    32'd225000,   32'd262500,   32'd375000,   32'd437500,
    32'd450000,   32'd525000,   32'd750000,   32'd875000,
    32'd900000,   32'd1050000,  32'd1125000,  32'd1312500,
    32'd1500000,  32'd1750000,  32'd1800000,  32'd2100000,
    32'd2250000,  32'd2625000,  32'd3000000,  32'd3500000,
    32'd3600000,  32'd4200000,  32'd4500000,  32'd5250000,
    32'd6000000,  32'd7000000,  32'd7200000,  32'd8400000,
    32'd9000000,  32'd10500000, 32'd12000000, 32'd14000000,
    32'd14400000, 32'd16800000, 32'd18000000, 32'd21000000,
    32'd24000000, 32'd28000000, 32'd28800000, 32'd33600000,
    32'd36000000, 32'd42000000, 32'd48000000, 32'd56000000,
    32'd72000000, 32'd84000000, 32'd144000000, 32'd168000000
  };

  // Divisor of each pair of panel entries; the odd entry adds the source bit.
  localparam logic [5:0] PANEL_DIV [PANEL_TABLE_LEN/2] = '{
    6'h17, 6'h0f, 6'h16, 6'h0e, 6'h15, 6'h07, 6'h0d, 6'h14,
    6'h06, 6'h0c, 6'h13, 6'h05, 6'h0b, 6'h12, 6'h04, 6'h0a,
    6'h11, 6'h03, 6'h09, 6'h10, 6'h02, 6'h08, 6'h01, 6'h00
  };

  localparam logic [31:0] CRT_HZ [CRT_TABLE_LEN] = '{
    32'd375000,   32'd437500,   32'd750000,   32'd875000,
    32'd1125000,  32'd1312500,  32'd1500000,  32'd1750000,
    32'd2250000,  32'd2625000,  32'd3000000,  32'd3500000,
    32'd4500000,  32'd5250000,  32'd6000000,  32'd7000000,
    32'd9000000,  32'd10500000, 32'd12000000, 32'd14000000,
    32'd18000000, 32'd21000000, 32'd24000000, 32'd28000000,
    32'd36000000, 32'd42000000, 32'd48000000, 32'd56000000,
    32'd72000000, 32'd84000000, 32'd144000000, 32'd168000000
  };

  localparam logic [4:0] CRT_DIV [CRT_TABLE_LEN/2] = '{
    5'h0f, 5'h0e, 5'h07, 5'h0d, 5'h06, 5'h0c, 5'h05, 5'h0b,
    5'h04, 5'h0a, 5'h03, 5'h09, 5'h02, 5'h08, 5'h01, 5'h00
  };

  // Midpoint between neighbors k and k+1, rounded down. A clock above it
  // is nearer the upper entry; a clock at it ties and stays low.
  function automatic logic [31:0] panel_mid(input int k);
    logic [32:0] sum;
    sum = {1'b0, PANEL_HZ[k]} + {1'b0, PANEL_HZ[k+1]};
    return sum[32:1];
  endfunction

  function automatic logic [31:0] crt_mid(input int k);
    logic [32:0] sum;
    sum = {1'b0, CRT_HZ[k]} + {1'b0, CRT_HZ[k+1]};
    return sum[32:1];
  endfunction

  function automatic logic [31:0] panel_bits(input int k);
    logic [31:0] bits;
    bits = {2'b00, PANEL_DIV[k/2], 24'h000000};
    if ((k % 2) == 1) bits = bits | PANEL_SRC;
    return bits;
  endfunction

  function automatic logic [31:0] crt_bits(input int k);
    logic [31:0] bits;
    bits = {11'h000, CRT_DIV[k/2], 16'h0000};
    if ((k % 2) == 1) bits = bits | CRT_SRC;
    return bits;
  endfunction

  // One mode request, fully worked out, waiting to be written out.
  typedef struct packed {
    logic        is_crt;
    logic [31:0] offs;
    logic [31:0] fb_w;
    logic [31:0] fb_h;
    logic [31:0] size;
    logic [31:0] htot;
    logic [31:0] hsyn;
    logic [31:0] vtot;
    logic [31:0] vsyn;
    logic [31:0] ctrl;
    logic [31:0] clk0;
    logic [31:0] clk1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/core/dmrs_front.sv]
// ----------------------------------------------------------------------------
// dmrs_front: request intake and classification
// Accepts a mode request, compares its clock against the table midpoints,
// then builds the packed geometry, control and clock words into a job.
// ----------------------------------------------------------------------------
module dmrs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dmrs_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [dmrs_pkg::IN_USER_W-1:0] in_user_i,
  input  logic [31:0]                    prior_disp_i,
  input  logic [31:0]                    prior_clk_i,
  input  dmrs_pkg::queue_status_t        q_status_i,
  output logic                           push_o,
  output dmrs_pkg::job_t                 job_o
);

  localparam int PTH_W = dmrs_pkg::PANEL_TABLE_LEN - 1;
  localparam int CTH_W = dmrs_pkg::CRT_TABLE_LEN - 1;

  logic             valid_q;
  logic [1:0]       target_q;
  logic [11:0]      x_q, y_q;
  logic [9:0]       lb_q, rb_q, tb_q, bb_q;
  logic [7:0]       hs_q;
  logic [5:0]       vs_q;
  logic             hz_zero_q, hz_one_q, rising_q, active_q;
  logic [PTH_W-1:0] pth_q, pth_d;
  logic [CTH_W-1:0] cth_q, cth_d;
  logic [31:0]      hz;
  logic             take;

  assign hz         = in_data_i[109:78];
  assign in_ready_o = !valid_q || !q_status_i.full;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = valid_q && !q_status_i.full;

  // Thermometer of "clock lies above midpoint k" for the searched entries.
  always_comb begin
    pth_d = '0;
    cth_d = '0;
    for (int k = 0; k < PTH_W; k++) begin
      if (k < dmrs_pkg::PANEL_COUNT - 1) pth_d[k] = hz > dmrs_pkg::panel_mid(k);
    end
    for (int k = 0; k < CTH_W; k++) begin
      if (k < dmrs_pkg::CRT_COUNT - 1) cth_d[k] = hz > dmrs_pkg::crt_mid(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      target_q  <= in_user_i;
      x_q       <= in_data_i[11:0];
      y_q       <= in_data_i[23:12];
      lb_q      <= in_data_i[33:24];
      rb_q      <= in_data_i[43:34];
      tb_q      <= in_data_i[53:44];
      bb_q      <= in_data_i[63:54];
      hs_q      <= in_data_i[71:64];
      vs_q      <= in_data_i[77:72];
      hz_zero_q <= (hz == 32'd0);
      hz_one_q  <= (hz == 32'd1);
      rising_q  <= in_data_i[110];
      active_q  <= in_data_i[111];
      pth_q     <= pth_d;
      cth_q     <= cth_d;
    end
  end

  // Job assembly from the registered request.
  logic [31:0]      x, y, lb, rb, tb, bb, hs, vs;
  logic [PTH_W+1:0] pext;
  logic [CTH_W+1:0] cext;
  logic [31:0]      pbits, cbits, disp, crt_ctrl, pclk, cclk;

  always_comb begin
    x  = {20'd0, x_q};
    y  = {20'd0, y_q};
    lb = {22'd0, lb_q};
    rb = {22'd0, rb_q};
    tb = {22'd0, tb_q};
    bb = {22'd0, bb_q};
    hs = {24'd0, hs_q};
    vs = {26'd0, vs_q};

    // The chosen entry sits where the thermometer steps from one to zero.
    pext  = {1'b0, pth_q, 1'b1};
    cext  = {1'b0, cth_q, 1'b1};
    pbits = '0;
    cbits = '0;
    for (int k = 0; k < dmrs_pkg::PANEL_TABLE_LEN; k++) begin
      if (pext[k] && !pext[k+1]) pbits = pbits | dmrs_pkg::panel_bits(k);
    end
    for (int k = 0; k < dmrs_pkg::CRT_TABLE_LEN; k++) begin
      if (cext[k] && !cext[k+1]) cbits = cbits | dmrs_pkg::crt_bits(k);
    end

    pclk = (prior_clk_i & ~dmrs_pkg::PANEL_CLK_FIELD) | pbits;
    cclk = (prior_clk_i & ~dmrs_pkg::CRT_CLK_FIELD) | cbits;

    disp = prior_disp_i & ~(dmrs_pkg::DISP_CLK_POL | dmrs_pkg::DISP_STN_TYPE |
                            dmrs_pkg::DISP_SIG_EN | dmrs_pkg::DISP_LOW_BITS);
    if (!rising_q) disp = disp | dmrs_pkg::DISP_CLK_POL;
    if (!active_q) disp = disp | dmrs_pkg::DISP_STN_TYPE;
    if (target_q == dmrs_pkg::TARGET_PANEL_ON) disp = disp | dmrs_pkg::DISP_SIG_EN;
    disp = disp | dmrs_pkg::DISP_ENABLE;

    crt_ctrl = dmrs_pkg::CRT_CTRL_BASE;
    if (!rising_q) crt_ctrl = crt_ctrl | dmrs_pkg::CRT_SYNC_PHASE;

    job_o.is_crt = target_q[1];
    job_o.offs   = (x << 16) + x;
    job_o.fb_w   = x << 16;
    job_o.fb_h   = y << 16;
    job_o.size   = ((y - 32'd1) << 16) + (x - 32'd1);
    job_o.htot   = ((lb + x + rb + hs - 32'd1) << 16) + x - 32'd1;
    job_o.hsyn   = (hs << 16) + (x + lb - 32'd1);
    job_o.vtot   = ((tb + y + bb + vs - 32'd1) << 16) + y - 32'd1;
    job_o.vsyn   = (vs << 16) + y + tb - 32'd1;

    if (target_q[1]) begin
      job_o.ctrl = crt_ctrl;
      job_o.clk0 = cclk;
      job_o.clk1 = cclk;
    end else begin
      job_o.ctrl = disp;
      if (hz_zero_q) begin
        job_o.clk0 = dmrs_pkg::PRESET0_CLK0;
        job_o.clk1 = dmrs_pkg::PRESET0_CLK1;
      end else if (hz_one_q) begin
        job_o.clk0 = dmrs_pkg::PRESET1_CLK;
        job_o.clk1 = dmrs_pkg::PRESET1_CLK;
      end else begin
        job_o.clk0 = pclk;
        job_o.clk1 = pclk;
      end
    end
  end

endmodule

[rtl/core/dmrs_queue.sv]
// ----------------------------------------------------------------------------
// dmrs_queue: job queue between front end and back end
// A two-entry FIFO of job records so that intake and write-out stall apart.
// ----------------------------------------------------------------------------
module dmrs_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  dmrs_pkg::job_t          job_i,
  input  logic                    pop_i,
  output dmrs_pkg::job_t          job_o,
  output dmrs_pkg::queue_status_t status_o
);

  // The head slot always holds the oldest job; the tail slot moves up on a pop.
  dmrs_pkg::job_t                     head_q, tail_q;
  logic [dmrs_pkg::QUEUE_CNT_W-1:0]   cnt_q;

  assign status_o.full  = (cnt_q == dmrs_pkg::QUEUE_CNT_W'(dmrs_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign job_o          = head_q;

  always_ff @(posedge clk_i) begin
    case ({push_i, pop_i})
      2'b10: begin
        if (cnt_q == '0) head_q <= job_i;
        else             tail_q <= job_i;
      end
      2'b01: begin
        head_q <= tail_q;
      end
      2'b11: begin
        if (cnt_q == dmrs_pkg::QUEUE_CNT_W'(1)) begin
          head_q <= job_i;
        end else begin
          head_q <= tail_q;
          tail_q <= job_i;
        end
      end
      default: begin
        head_q <= head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/core/dmrs_back.sv]
// ----------------------------------------------------------------------------
// dmrs_back: register write sequencer
// Steps through the job at the queue head and presents one register write
// per cycle, while the sink is ready, from an output register.
// ----------------------------------------------------------------------------
module dmrs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dmrs_pkg::job_t                     job_i,
  input  dmrs_pkg::queue_status_t            q_status_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dmrs_pkg::OFFSET_W-1:0]      out_offset_o,
  output logic [31:0]                        out_value_o,
  output logic                               out_last_o
);

  logic [dmrs_pkg::STEP_W-1:0]   step_q, step_d;
  logic                          valid_q, valid_d;
  logic [dmrs_pkg::OFFSET_W-1:0] offset_q, offset_d;
  logic [31:0]                   value_q, value_d;
  logic                          last_q, last_d;
  logic                          load;
  logic [dmrs_pkg::STEP_W-1:0]   last_step;

  assign load      = !q_status_i.empty && (!valid_q || out_ready_i);
  assign last_step = job_i.is_crt ? dmrs_pkg::CRT_LAST_STEP : dmrs_pkg::PANEL_LAST_STEP;
  assign last_d    = (step_q == last_step);
  assign pop_o     = load && last_d;

  always_comb begin
    offset_d = dmrs_pkg::OFF_CLK2;
    value_d  = job_i.clk1;
    if (job_i.is_crt) begin
      case (step_q)
        4'd0: begin offset_d = dmrs_pkg::OFF_C_OFFS;   value_d = job_i.offs; end
        4'd1: begin offset_d = dmrs_pkg::OFF_C_HTOT;   value_d = job_i.htot; end
        4'd2: begin offset_d = dmrs_pkg::OFF_C_HSYN;   value_d = job_i.hsyn; end
        4'd3: begin offset_d = dmrs_pkg::OFF_C_VTOT;   value_d = job_i.vtot; end
        4'd4: begin offset_d = dmrs_pkg::OFF_C_VSYN;   value_d = job_i.vsyn; end
        4'd5: begin offset_d = dmrs_pkg::OFF_CRT_CTRL; value_d = job_i.ctrl; end
        4'd6: begin offset_d = dmrs_pkg::OFF_CLK0;     value_d = job_i.clk0; end
        4'd7: begin offset_d = dmrs_pkg::OFF_CLK1;     value_d = job_i.clk0; end
        default: begin offset_d = dmrs_pkg::OFF_CLK2;  value_d = job_i.clk1; end
      endcase
    end else begin
      case (step_q)
        4'd0:  begin offset_d = dmrs_pkg::OFF_P_OFFS; value_d = job_i.offs; end
        4'd1:  begin offset_d = dmrs_pkg::OFF_P_FB_W; value_d = job_i.fb_w; end
        4'd2:  begin offset_d = dmrs_pkg::OFF_P_FB_H; value_d = job_i.fb_h; end
        4'd3:  begin offset_d = dmrs_pkg::OFF_P_SIZE; value_d = job_i.size; end
        4'd4:  begin offset_d = dmrs_pkg::OFF_P_HTOT; value_d = job_i.htot; end
        4'd5:  begin offset_d = dmrs_pkg::OFF_P_HSYN; value_d = job_i.hsyn; end
        4'd6:  begin offset_d = dmrs_pkg::OFF_P_VTOT; value_d = job_i.vtot; end
        4'd7:  begin offset_d = dmrs_pkg::OFF_P_VSYN; value_d = job_i.vsyn; end
        4'd8:  begin offset_d = dmrs_pkg::OFF_CLK0;   value_d = job_i.clk0; end
        4'd9:  begin offset_d = dmrs_pkg::OFF_CLK1;   value_d = job_i.clk0; end
        4'd10: begin offset_d = dmrs_pkg::OFF_CLK2;   value_d = job_i.clk1; end
        default: begin offset_d = dmrs_pkg::OFF_DISP_CTRL; value_d = job_i.ctrl; end
      endcase
    end
  end

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      step_d  = last_d ? '0 : step_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      offset_q <= offset_d;
      value_q  <= value_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_offset_o = offset_q;
  assign out_value_o  = value_q;
  assign out_last_o   = last_q;

endmodule

[rtl/core/display_mode_register_sequencer.sv]
// Path: the first register write of a request goes from the front end's request
//   register through the job queue to the back end's output register; the rest
//   follow one per cycle while the sink is ready. A panel request makes 12 writes
//   and a CRT request 9, all from the back end's single output register.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and
//   queue and clears both configuration registers to zero.
// ----------------------------------------------------------------------------
// display_mode_register_sequencer: display mode to register write sequence
// Turns one display-mode request into the ordered register writes that set
// up the display controller's geometry, control word and pixel clock.
// ----------------------------------------------------------------------------
module display_mode_register_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream.
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // tdata, lowest bit first: h_pixels[11:0], v_lines[23:12],
  // left_blank[33:24], right_blank[43:34], top_blank[53:44],
  // bottom_blank[63:54], hsync_width[71:64], vsync_width[77:72],
  // pixel_clock_hz[109:78], rising_edge_clock[110], active_matrix[111]
  input  logic [dmrs_pkg::IN_DATA_W-1:0]  s_tdata_i,
  // tuser: target[1:0]
  input  logic [dmrs_pkg::IN_USER_W-1:0]  s_tuser_i,
  // Register write stream.
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // tdata, lowest bit first: register offset[20:0], write data[52:21],
  // zeros above
  output logic [dmrs_pkg::OUT_DATA_W-1:0] m_tdata_o,
  // tlast: last_write
  output logic                            m_tlast_o,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // The two configuration registers keep the bits of the current display
  // control and clock control words that a mode change must not disturb.
  // Address 0 holds the display control word and address 4 the clock word.
  logic [31:0] prior_disp_q, prior_clk_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[2] ? prior_clk_q : prior_disp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_disp_q <= '0;
      prior_clk_q  <= '0;
    end else if (cfg_write) begin
      if (paddr[2]) prior_clk_q <= pwdata;
      else          prior_disp_q <= pwdata;
    end
  end

  // The front end registers each request together with the result of
  // comparing its clock against every midpoint of both frequency tables,
  // then turns it into a job holding all words to be written.
  dmrs_pkg::job_t          front_job, head_job;
  dmrs_pkg::queue_status_t q_status;
  logic                    q_push, q_pop;

  dmrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .in_data_i    (s_tdata_i),
    .in_user_i    (s_tuser_i),
    .prior_disp_i (prior_disp_q),
    .prior_clk_i  (prior_clk_q),
    .q_status_i   (q_status),
    .push_o       (q_push),
    .job_o        (front_job)
  );

  // Two jobs of slack let a new request be accepted while the back end is
  // still writing out the previous one.
  dmrs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .job_i    (front_job),
    .pop_i    (q_pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  // The back end walks the head job one write per cycle when not stalled and
  // releases it from the queue when its final write enters the output register.
  logic [dmrs_pkg::OFFSET_W-1:0] out_offset;
  logic [31:0]                   out_value;

  dmrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .q_status_i   (q_status),
    .pop_o        (q_pop),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_offset_o (out_offset),
    .out_value_o  (out_value),
    .out_last_o   (m_tlast_o)
  );

  assign m_tdata_o = {3'b000, out_value, out_offset};

`ifndef NO_ASSERTIONS
  // The front end never pushes a job into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_status.full)
    else $error("job pushed into a full queue");

  // The back end never releases a job that is not there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  // The final write of a request is the panel control word or the last
  // clock-control word of a CRT request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_tvalid_o && m_tlast_o) |->
      (m_tdata_o[20:0] == dmrs_pkg::OFF_DISP_CTRL || m_tdata_o[20:0] == dmrs_pkg::OFF_CLK2))
    else $error("final write at an unexpected register");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the display mode register sequencer
// Mode requests are streamed into the block and every register write that
// comes back is compared field by field, in order, against a predictor
// inside the bench. The predictor rebuilds the geometry words, the control
// word and the pixel clock selection. The run is split into phases. Between
// phases the two prior-value registers are rewritten over APB while the
// block is idle. Random stalls are applied on both streams, and the last
// phase runs at full rate.
// ----------------------------------------------------------------------------
module testbench;

  // Target codes. Bit 1 alone selects the CRT, so the alias behaves as CRT.
  localparam logic [1:0] TARGET_PANEL_ON  = dmrs_pkg::TARGET_PANEL_ON;
  localparam logic [1:0] TARGET_PANEL_OFF = dmrs_pkg::TARGET_PANEL_OFF;
  localparam logic [1:0] TARGET_CRT       = 2'd2;
  localparam logic [1:0] TARGET_CRT_ALIAS = 2'd3;

  // Configuration register indexes; each register sits at byte address 4*index.
  localparam int REG_DISPLAY_CTRL = 0;
  localparam int REG_CLOCK_CTRL   = 1;

  // Register offsets written by the block.
  localparam logic [20:0] WR_CLK0      = 21'h0003C;
  localparam logic [20:0] WR_CLK1      = 21'h00044;
  localparam logic [20:0] WR_CLK2      = 21'h0004C;
  localparam logic [20:0] WR_DISP_CTRL = 21'h80000;
  localparam logic [20:0] WR_P_OFFS    = 21'h80010;
  localparam logic [20:0] WR_P_FB_W    = 21'h80014;
  localparam logic [20:0] WR_P_FB_H    = 21'h80018;
  localparam logic [20:0] WR_P_SIZE    = 21'h80020;
  localparam logic [20:0] WR_P_HTOT    = 21'h80024;
  localparam logic [20:0] WR_P_HSYN    = 21'h80028;
  localparam logic [20:0] WR_P_VTOT    = 21'h8002C;
  localparam logic [20:0] WR_P_VSYN    = 21'h80030;
  localparam logic [20:0] WR_CRT_CTRL  = 21'h80200;
  localparam logic [20:0] WR_C_OFFS    = 21'h80208;
  localparam logic [20:0] WR_C_HTOT    = 21'h8020C;
  localparam logic [20:0] WR_C_HSYN    = 21'h80210;
  localparam logic [20:0] WR_C_VTOT    = 21'h80214;
  localparam logic [20:0] WR_C_VSYN    = 21'h80218;

  // Control-word bits.
  localparam logic [31:0] CRT_CTRL_INIT  = 32'h00010304;
  localparam logic [31:0] CRT_PHASES     = 32'h3 << 14;
  localparam logic [31:0] PANEL_CLK_BITS = 32'h3F << 24;
  localparam logic [31:0] CRT_CLK_BITS   = 32'h1F << 16;
  localparam logic [31:0] PANEL_SRC_BIT  = 32'h1 << 29;
  localparam logic [31:0] CRT_SRC_BIT    = 32'h1 << 20;
  localparam logic [31:0] DISP_POL       = 32'h1 << 14;
  localparam logic [31:0] DISP_STN       = 32'h3 << 18;
  localparam logic [31:0] DISP_SIGNALS   = 32'hF << 24;
  localparam logic [31:0] DISP_LOW       = 32'h3;
  localparam logic [31:0] DISP_ON        = 32'h4;
  localparam logic [31:0] PRESET_A_CLK0  = 32'h0A1A0201;
  localparam logic [31:0] PRESET_A_CLK1  = 32'h0A1A0A09;
  localparam logic [31:0] PRESET_B_CLK   = 32'h291A0201;

  // Searched table sizes, already clamped to the table lengths.
  localparam int PANEL_RATES = 48;
  localparam int CRT_RATES   = 32;

  // Pixel clock tables, sorted. Each pair of entries shares one divisor; the
  // odd entry of a pair also sets the source bit.
  localparam logic [31:0] PANEL_RATE [PANEL_RATES] = '{
    225000,   262500,   375000,   437500,   450000,   525000,   750000,   875000,
    900000,   1050000,  1125000,  1312500,  1500000,  1750000,  1800000,  2100000,
    2250000,  2625000,  3000000,  3500000,  3600000,  4200000,  4500000,  5250000,
    6000000,  7000000,  7200000,  8400000,  9000000,  10500000, 12000000, 14000000,
    14400000, 16800000, 18000000, 21000000, 24000000, 28000000, 28800000, 33600000,
    36000000, 42000000, 48000000, 56000000, 72000000, 84000000, 144000000, 168000000
  };
  localparam logic [5:0] PANEL_DIVISOR [PANEL_RATES/2] = '{
    6'h17, 6'h0f, 6'h16, 6'h0e, 6'h15, 6'h07, 6'h0d, 6'h14,
    6'h06, 6'h0c, 6'h13, 6'h05, 6'h0b, 6'h12, 6'h04, 6'h0a,
    6'h11, 6'h03, 6'h09, 6'h10, 6'h02, 6'h08, 6'h01, 6'h00
  };
  localparam logic [31:0] CRT_RATE [CRT_RATES] = '{
    375000,   437500,   750000,   875000,   1125000,  1312500,  1500000,  1750000,
    2250000,  2625000,  3000000,  3500000,  4500000,  5250000,  6000000,  7000000,
    9000000,  10500000, 12000000, 14000000, 18000000, 21000000, 24000000, 28000000,
    36000000, 42000000, 48000000, 56000000, 72000000, 84000000, 144000000, 168000000
  };
  localparam logic [4:0] CRT_DIVISOR [CRT_RATES/2] = '{
    5'h0f, 5'h0e, 5'h07, 5'h0d, 5'h06, 5'h0c, 5'h05, 5'h0b,
    5'h04, 5'h0a, 5'h03, 5'h09, 5'h02, 5'h08, 5'h01, 5'h00
  };

  typedef struct packed {
    logic [1:0]  target;
    logic [11:0] h_pixels;
    logic [11:0] v_lines;
    logic [9:0]  left;
    logic [9:0]  right;
    logic [9:0]  top;
    logic [9:0]  bottom;
    logic [7:0]  hsync;
    logic [5:0]  vsync;
    logic [31:0] pixel_hz;
    logic        rising;
    logic        active;
  } mode_req_t;

  typedef struct packed {
    logic [20:0] offset;
    logic [31:0] value;
    logic        last;
  } reg_write_t;

  // Clock, reset and every block input start at known values.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic [dmrs_pkg::IN_DATA_W-1:0] s_tdata_i = '0;
  logic [dmrs_pkg::IN_USER_W-1:0] s_tuser_i = '0;
  logic m_tready_i = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;

  logic s_tready_o;
  logic m_tvalid_o;
  logic [dmrs_pkg::OUT_DATA_W-1:0] m_tdata_o;
  logic m_tlast_o;
  logic [31:0] prdata;
  logic pready;

  // Requests waiting to be sent, and the register writes the block owes us.
  mode_req_t  pending_modes[$];
  reg_write_t expected_writes[$];

  // Our copy of the two configuration registers.
  logic [31:0] cfg_display_ctrl = '0;
  logic [31:0] cfg_clock_ctrl = '0;

  int  error_count = 0;
  int  writes_checked = 0;
  int  panel_modes = 0;
  int  crt_modes = 0;
  int  preset_modes = 0;
  int  src_gap = 0;
  int  sink_stall = 0;
  bit  full_rate = 1'b0;
  mode_req_t mode_in_flight;

  display_mode_register_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk_i = ~clk_i;

  // Nearest table entry to the wanted clock, ties to the lower entry. A clock
  // below the first entry or above the last one is clamped to that end.
  function automatic logic [31:0] nearest_clock_bits(logic [31:0] hz, bit crt);
    int n;
    int i;
    int pick;
    logic [31:0] rate_hi;
    logic [31:0] rate_lo;
    logic [31:0] bits;
    n = crt ? CRT_RATES : PANEL_RATES;
    i = 0;
    while (i < n && (crt ? CRT_RATE[i] : PANEL_RATE[i]) <= hz) i++;
    if (i == 0) begin
      pick = 0;
    end else if (i >= n) begin
      pick = n - 1;
    end else begin
      rate_hi = crt ? CRT_RATE[i] : PANEL_RATE[i];
      rate_lo = crt ? CRT_RATE[i-1] : PANEL_RATE[i-1];
      pick = (rate_hi - hz < hz - rate_lo) ? i : i - 1;
    end
    if (crt) begin
      bits = {11'd0, CRT_DIVISOR[pick/2], 16'd0};
      if (pick % 2 == 1) bits |= CRT_SRC_BIT;
    end else begin
      bits = {2'd0, PANEL_DIVISOR[pick/2], 24'd0};
      if (pick % 2 == 1) bits |= PANEL_SRC_BIT;
    end
    return bits;
  endfunction

  function automatic void add_write(logic [20:0] offset, logic [31:0] value, logic last);
    reg_write_t w;
    w.offset = offset;
    w.value = value;
    w.last = last;
    expected_writes.push_back(w);
  endfunction

  // Works out the full write sequence for one accepted mode request. All
  // packed words use 32-bit wrap-around, so zero sizes wrap as the block does.
  function automatic void predict_mode_writes(mode_req_t m);
    logic [31:0] x, y, lb, rb, tb, bb, hs, vs;
    logic [31:0] htot, hsyn, vtot, vsyn, offs, ctrl, clk, disp, c0, c1;
    x = {20'd0, m.h_pixels};
    y = {20'd0, m.v_lines};
    lb = {22'd0, m.left};
    rb = {22'd0, m.right};
    tb = {22'd0, m.top};
    bb = {22'd0, m.bottom};
    hs = {24'd0, m.hsync};
    vs = {26'd0, m.vsync};
    htot = ((lb + x + rb + hs - 32'd1) << 16) + x - 32'd1;
    hsyn = (hs << 16) + (x + lb - 32'd1);
    vtot = ((tb + y + bb + vs - 32'd1) << 16) + y - 32'd1;
    vsyn = (vs << 16) + y + tb - 32'd1;
    offs = (x << 16) + x;
    if (m.target[1]) begin
      crt_modes++;
      ctrl = CRT_CTRL_INIT;
      if (!m.rising) ctrl |= CRT_PHASES;
      clk = (cfg_clock_ctrl & ~CRT_CLK_BITS) | nearest_clock_bits(m.pixel_hz, 1'b1);
      add_write(WR_C_OFFS, offs, 1'b0);
      add_write(WR_C_HTOT, htot, 1'b0);
      add_write(WR_C_HSYN, hsyn, 1'b0);
      add_write(WR_C_VTOT, vtot, 1'b0);
      add_write(WR_C_VSYN, vsyn, 1'b0);
      add_write(WR_CRT_CTRL, ctrl, 1'b0);
      add_write(WR_CLK0, clk, 1'b0);
      add_write(WR_CLK1, clk, 1'b0);
      add_write(WR_CLK2, clk, 1'b1);
    end else begin
      panel_modes++;
      disp = cfg_display_ctrl & ~(DISP_POL | DISP_STN | DISP_SIGNALS | DISP_LOW);
      if (!m.rising) disp |= DISP_POL;
      if (!m.active) disp |= DISP_STN;
      if (m.target == TARGET_PANEL_ON) disp |= DISP_SIGNALS;
      disp |= DISP_ON;
      // Clocks of 0 and 1 pick fixed presets on the panel side only.
      if (m.pixel_hz == 32'd0) begin
        preset_modes++;
        c0 = PRESET_A_CLK0;
        c1 = PRESET_A_CLK1;
      end else if (m.pixel_hz == 32'd1) begin
        preset_modes++;
        c0 = PRESET_B_CLK;
        c1 = PRESET_B_CLK;
      end else begin
        c0 = (cfg_clock_ctrl & ~PANEL_CLK_BITS) | nearest_clock_bits(m.pixel_hz, 1'b0);
        c1 = c0;
      end
      add_write(WR_P_OFFS, offs, 1'b0);
      add_write(WR_P_FB_W, x << 16, 1'b0);
      add_write(WR_P_FB_H, y << 16, 1'b0);
      add_write(WR_P_SIZE, ((y - 32'd1) << 16) + (x - 32'd1), 1'b0);
      add_write(WR_P_HTOT, htot, 1'b0);
      add_write(WR_P_HSYN, hsyn, 1'b0);
      add_write(WR_P_VTOT, vtot, 1'b0);
      add_write(WR_P_VSYN, vsyn, 1'b0);
      add_write(WR_CLK0, c0, 1'b0);
      add_write(WR_CLK1, c0, 1'b0);
      add_write(WR_CLK2, c1, 1'b0);
      add_write(WR_DISP_CTRL, disp, 1'b1);
    end
  endfunction

  function automatic mode_req_t make_mode(logic [1:0] target, logic [11:0] x, logic [11:0] y,
                                          logic [9:0] lb, logic [9:0] rb, logic [9:0] tb,
                                          logic [9:0] bb, logic [7:0] hs, logic [5:0] vs,
                                          logic [31:0] hz, logic rising, logic active);
    mode_req_t m;
    m.target = target;
    m.h_pixels = x;
    m.v_lines = y;
    m.left = lb;
    m.right = rb;
    m.top = tb;
    m.bottom = bb;
    m.hsync = hs;
    m.vsync = vs;
    m.pixel_hz = hz;
    m.rising = rising;
    m.active = active;
    return m;
  endfunction

  // Mostly full-range values, with zero, one and all-ones mixed in.
  function automatic logic [31:0] rand_field(int bits);
    logic [31:0] mask;
    mask = 32'hFFFF_FFFF >> (32 - bits);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // Random request. The clock is steered toward table entries, the midpoints
  // between neighbors and the presets, since that is where selection can slip.
  function automatic mode_req_t random_mode();
    mode_req_t m;
    int k;
    m.target = 2'($urandom_range(0, 3));
    m.h_pixels = 12'(rand_field(12));
    m.v_lines = 12'(rand_field(12));
    m.left = 10'(rand_field(10));
    m.right = 10'(rand_field(10));
    m.top = 10'(rand_field(10));
    m.bottom = 10'(rand_field(10));
    m.hsync = 8'(rand_field(8));
    m.vsync = 6'(rand_field(6));
    m.rising = 1'($urandom_range(0, 1));
    m.active = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: m.pixel_hz = $urandom_range(0, 1);
      1: begin
        k = $urandom_range(0, PANEL_RATES - 1);
        m.pixel_hz = PANEL_RATE[k] + $urandom_range(0, 6) - 3;
      end
      2: begin
        k = $urandom_range(0, CRT_RATES - 1);
        m.pixel_hz = CRT_RATE[k] + $urandom_range(0, 6) - 3;
      end
      3: begin
        k = $urandom_range(0, PANEL_RATES - 2);
        m.pixel_hz = (PANEL_RATE[k] + PANEL_RATE[k+1]) / 2 + $urandom_range(0, 2) - 1;
      end
      4: begin
        k = $urandom_range(0, CRT_RATES - 2);
        m.pixel_hz = (CRT_RATE[k] + CRT_RATE[k+1]) / 2 + $urandom_range(0, 2) - 1;
      end
      5: m.pixel_hz = $urandom;
      6: m.pixel_hz = $urandom_range(0, 400000);
      default: m.pixel_hz = $urandom_range(100000, 180000000);
    endcase
    return m;
  endfunction

  // Request driver. A new request is put on the bus only once the previous
  // one has been taken; between transactions it may idle for a random burst.
  // The prediction is made at the edge where the transaction completes, using
  // the configuration that is in force at that moment.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i <= '0;
      s_tuser_i <= '0;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        predict_mode_writes(mode_in_flight);
        if (!full_rate && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 12);
      end
      if (s_tvalid_i && !s_tready_o) begin
        // Hold the current request until the block takes it.
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid_i <= 1'b0;
      end else if (pending_modes.size() != 0) begin
        mode_in_flight = pending_modes.pop_front();
        s_tvalid_i <= 1'b1;
        s_tuser_i <= mode_in_flight.target;
        s_tdata_i <= {mode_in_flight.active, mode_in_flight.rising, mode_in_flight.pixel_hz,
                      mode_in_flight.vsync, mode_in_flight.hsync, mode_in_flight.bottom,
                      mode_in_flight.top, mode_in_flight.right, mode_in_flight.left,
                      mode_in_flight.v_lines, mode_in_flight.h_pixels};
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // Write-stream receiver: ready most of the time, with random stall bursts
  // that can land on any write of a sequence.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready_i <= 1'b0;
    end else if (!full_rate && $urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(1, 12) - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // Monitor: every completed write transaction is matched against the oldest
  // expected write, one field at a time.
  always @(posedge clk_i) begin
    reg_write_t exp_w;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_writes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected write, offset %h value %h last %b", $time,
                 m_tdata_o[20:0], m_tdata_o[52:21], m_tlast_o);
      end else begin
        exp_w = expected_writes.pop_front();
        writes_checked++;
        if (m_tdata_o[20:0] !== exp_w.offset) begin
          error_count++;
          $display("%0t: offset mismatch, expected %h actual %h", $time,
                   exp_w.offset, m_tdata_o[20:0]);
        end
        if (m_tdata_o[52:21] !== exp_w.value) begin
          error_count++;
          $display("%0t: value mismatch at offset %h, expected %h actual %h", $time,
                   exp_w.offset, exp_w.value, m_tdata_o[52:21]);
        end
        if (m_tlast_o !== exp_w.last) begin
          error_count++;
          $display("%0t: last mismatch at offset %h, expected %b actual %b", $time,
                   exp_w.offset, exp_w.last, m_tlast_o);
        end
        if (m_tdata_o[55:53] !== 3'b000) begin
          error_count++;
          $display("%0t: padding mismatch, expected %b actual %b", $time,
                   3'b000, m_tdata_o[55:53]);
        end
      end
    end
  end

  // Waits until every request has been sent and every write has come back,
  // then lets the pipeline settle.
  task automatic wait_until_idle();
    while (pending_modes.size() != 0 || s_tvalid_i || expected_writes.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write (setup then access), followed by a read-back of the same register.
  task automatic write_register(int index, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * index);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (index == REG_DISPLAY_CTRL) cfg_display_ctrl = value;
    else cfg_clock_ctrl = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      error_count++;
      $display("%0t: read-back of register %0d, expected %h actual %h", $time,
               index, value, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_phase(logic [31:0] disp_ctrl, logic [31:0] clk_ctrl, int count);
    write_register(REG_DISPLAY_CTRL, disp_ctrl);
    write_register(REG_CLOCK_CTRL, clk_ctrl);
    repeat (count) pending_modes.push_back(random_mode());
    wait_until_idle();
  endtask

  // Generous upper bound on the whole run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d writes still expected", expected_writes.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests, with both prior-value registers still at reset.
    // Field extremes and zero sizes, both presets, the CRT alias, clocks
    // below, at and above the tables, and exact midpoint ties.
    pending_modes.push_back(make_mode(TARGET_PANEL_ON, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_modes.push_back(make_mode(TARGET_PANEL_OFF, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF,
                                      10'h3FF, 10'h3FF, 8'hFF, 6'h3F, 1, 1, 1));
    pending_modes.push_back(make_mode(TARGET_CRT, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF,
                                      10'h3FF, 10'h3FF, 8'hFF, 6'h3F, 0, 0, 0));
    pending_modes.push_back(make_mode(TARGET_CRT_ALIAS, 1, 1, 0, 0, 0, 0, 0, 0, 1, 1, 1));
    pending_modes.push_back(make_mode(TARGET_PANEL_ON, 640, 480, 40, 24, 32, 11, 96, 2,
                                      2, 1, 1));
    pending_modes.push_back(make_mode(TARGET_PANEL_ON, 800, 600, 88, 40, 23, 1, 128, 4,
                                      32'hFFFF_FFFF, 1, 0));
    pending_modes.push_back(make_mode(TARGET_CRT, 1024, 768, 160, 24, 29, 3, 136, 6,
                                      32'hFFFF_FFFF, 1, 1));
    pending_modes.push_back(make_mode(TARGET_PANEL_OFF, 320, 240, 8, 8, 4, 4, 16, 2,
                                      243750, 0, 1));
    pending_modes.push_back(make_mode(TARGET_PANEL_OFF, 320, 240, 8, 8, 4, 4, 16, 2,
                                      243751, 0, 1));
    pending_modes.push_back(make_mode(TARGET_CRT, 640, 480, 48, 16, 33, 10, 96, 2,
                                      406250, 1, 1));
    pending_modes.push_back(make_mode(TARGET_CRT, 640, 480, 48, 16, 33, 10, 96, 2,
                                      406251, 0, 1));
    pending_modes.push_back(make_mode(TARGET_PANEL_ON, 1280, 1024, 248, 48, 38, 1, 112, 3,
                                      156000000, 1, 1));
    pending_modes.push_back(make_mode(TARGET_CRT_ALIAS, 640, 400, 48, 16, 35, 12, 96, 2,
                                      374999, 1, 0));
    pending_modes.push_back(make_mode(TARGET_PANEL_ON, 240, 320, 20, 10, 2, 4, 10, 2,
                                      225000, 1, 0));
    pending_modes.push_back(make_mode(TARGET_CRT, 1920, 1080, 148, 88, 36, 4, 44, 5,
                                      168000000, 0, 1));
    pending_modes.push_back(make_mode(TARGET_PANEL_OFF, 800, 480, 46, 210, 23, 22, 20, 10,
                                      25175000, 0, 0));
    pending_modes.push_back(make_mode(TARGET_CRT, 1024, 768, 160, 24, 29, 3, 136, 6,
                                      65000000, 1, 1));
    pending_modes.push_back(make_mode(TARGET_PANEL_ON, 160, 120, 4, 4, 2, 2, 8, 1,
                                      224999, 1, 0));
    wait_until_idle();

    // Random phases under several register settings, extremes included.
    // The last one runs with no idling on either stream.
    run_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 70);
    run_random_phase($urandom, $urandom, 70);
    run_random_phase(32'h0000_0000, 32'h0000_0000, 60);
    full_rate = 1'b1;
    run_random_phase($urandom, $urandom, 62);
    repeat (16) @(posedge clk_i);

    $display("Checked %0d register writes from %0d panel and %0d CRT mode requests",
             writes_checked, panel_modes, crt_modes);
    $display("%0d panel requests used a preset clock; %0d mismatches seen",
             preset_modes, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dmrs_pkg.sv
rtl/core/dmrs_front.sv
rtl/core/dmrs_queue.sv
rtl/core/dmrs_back.sv
rtl/core/display_mode_register_sequencer.sv
sim/testbench.sv
